// File: sv/psic_pkg.sv
// psic_pkg: shared types and constants of the pedal and steering input conditioner
// no dependencies
package psic_pkg;
	localparam int FB = 14;
	localparam logic signed [17:0] ONE = 18'sd16384;
	localparam logic signed [17:0] TENTH = 18'sd1638;
	localparam logic [10:0] GAIN_MIN = 11'd26;
	localparam logic [10:0] GAIN_MAX = 11'd1280;
	localparam logic signed [15:0] SPEED_HALF = 16'sd128;

	localparam logic [2:0] REG_THR_GAIN = 3'd0;
	localparam logic [2:0] REG_STR_GAIN = 3'd1;
	localparam logic [2:0] REG_DZ = 3'd2;
	localparam logic [2:0] REG_BLEND = 3'd3;
	localparam logic [2:0] REG_AUTO_REV = 3'd4;

	typedef struct packed {
		logic               command;
		logic signed [15:0] throttle_raw;
		logic [14:0]        brake_raw;
		logic signed [15:0] steering_raw;
		logic               handbrake_raw;
		logic signed [15:0] road_speed;
	} in_item_t;

	typedef struct packed {
		logic [14:0]        drive_throttle;
		logic [14:0]        drive_brake;
		logic signed [15:0] drive_steering;
		logic               drive_handbrake;
		logic               reversing;
	} out_item_t;

	// datapath steps, in order of use, but OP_CLEAR is issued right after OP_LOAD
	typedef enum logic [2:0] {
		OP_LOAD, OP_DZ_START, OP_DZ_FINISH, OP_GAIN, OP_BLEND, OP_DECIDE, OP_CLEAR
	} op_t;

	typedef struct packed {
		logic       go;
		op_t        op;
		logic [1:0] lane;
	} dp_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic is_clear;
	} dp_status_t;
endpackage

// File: sv/psic_div.sv
// psic_div: restoring divider, one quotient bit per cycle
// depends on psic_pkg
module psic_div import psic_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [14:0] num,
	input  logic [14:0] den,
	output logic        busy,
	output logic [14:0] quot
);
	// quotient of (num << 14) / den, num <= den so result fits 15 bits
	logic [4:0]  cnt_q;
	logic [15:0] rem_q;
	logic [14:0] den_q;
	logic [16:0] trial;

	assign trial = {rem_q, 1'b0} - {2'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 5'(FB);
		end else if (cnt_q != 0) begin
			cnt_q <= cnt_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// integer bit first: num equal to den gives exactly one
			if (num >= den) begin
				rem_q <= {1'b0, num - den};
				quot  <= 15'd1;
			end else begin
				rem_q <= {1'b0, num};
				quot  <= '0;
			end
			den_q <= den;
		end else if (cnt_q != 0) begin
			if (!trial[16]) begin
				rem_q <= trial[15:0];
				quot  <= {quot[13:0], 1'b1};
			end else begin
				rem_q <= {rem_q[14:0], 1'b0};
				quot  <= {quot[13:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != 0);
endmodule

// File: sv/psic_datapath.sv
// psic_datapath: registers, dead zone, gain, blend and reverse logic
// depends on psic_pkg and psic_div
module psic_datapath import psic_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	input  in_item_t    in_item,
	input  logic [10:0] thr_gain,
	input  logic [10:0] str_gain,
	input  logic [13:0] dz_width,
	input  logic [14:0] blend_rate,
	input  logic        auto_rev,
	output dp_status_t  status,
	output out_item_t   result
);
	logic signed [17:0] val_q [3];     // lane 0 throttle, 1 steering, 2 brake
	logic signed [15:0] thr_f_q, str_f_q;
	logic               rev_q;
	logic signed [15:0] speed_q;
	logic               hb_q, clr_q;
	logic [14:0]        dz, bl;
	logic [10:0]        gsel;
	logic signed [17:0] cur;
	logic [14:0]        mag;
	logic               neg;
	logic               div_start, div_busy;
	logic [14:0]        quot;
	logic [25:0]        gprod;
	logic [15:0]        gres;
	logic signed [17:0] diff;
	logic signed [33:0] bprod;
	logic [33:0]        pmag;
	logic signed [17:0] step, nf;
	logic signed [17:0] tf, brk, thr_in, str_in;
	logic [14:0]        brk_in;
	logic               rev_n;

	assign dz = (dz_width > 14'd8192) ? 15'd8192 : {1'b0, dz_width};
	assign bl = (blend_rate > 15'd16384) ? 15'd16384 : blend_rate;
	assign cur = val_q[cmd.lane];
	assign neg = cur[17];
	assign mag = neg ? 15'(-cur) : cur[14:0];
	assign div_start = cmd.go && cmd.op == OP_DZ_START && mag >= dz;

	psic_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(mag - dz), .den(15'd16384 - dz), .busy(div_busy), .quot(quot)
	);

	always_comb begin
		gsel = (cmd.lane == 2'd0) ? thr_gain : str_gain;
		if (gsel < GAIN_MIN) gsel = GAIN_MIN;
		else if (gsel > GAIN_MAX) gsel = GAIN_MAX;
	end
	assign gprod = 26'(mag) * 26'(gsel);
	assign gres = (gprod[25:8] > 18'd16384) ? 16'd16384 : gprod[23:8];

	assign diff = (cmd.lane == 2'd0) ? cur - 18'(thr_f_q) : cur - 18'(str_f_q);
	assign bprod = 34'(diff) * $signed({19'b0, bl});
	assign pmag = bprod[33] ? -bprod : bprod;
	// round to nearest, ties away from zero
	assign step = bprod[33] ? -18'((pmag + 34'd8192) >> FB) : 18'((pmag + 34'd8192) >> FB);
	assign nf = ((cmd.lane == 2'd0) ? 18'(thr_f_q) : 18'(str_f_q)) + step;

	assign tf = 18'(thr_f_q);
	assign brk = val_q[2];
	always_comb begin
		rev_n = rev_q;
		if (auto_rev) begin
			if (speed_q < SPEED_HALF && brk > TENTH && tf < TENTH) rev_n = 1'b1;
			if (tf > TENTH) rev_n = 1'b0;
		end else begin
			rev_n = tf[17];
		end
	end

	assign thr_in = (in_item.throttle_raw > 16'sd16384) ? ONE :
		(in_item.throttle_raw < -16'sd16384) ? -ONE : 18'(in_item.throttle_raw);
	assign str_in = (in_item.steering_raw > 16'sd16384) ? ONE :
		(in_item.steering_raw < -16'sd16384) ? -ONE : 18'(in_item.steering_raw);
	assign brk_in = (in_item.brake_raw > 15'd16384) ? 15'd16384 : in_item.brake_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_f_q <= '0;
			str_f_q <= '0;
			rev_q   <= 1'b0;
		end else if (cmd.go) begin
			if (cmd.op == OP_CLEAR) begin
				thr_f_q <= '0;
				str_f_q <= '0;
				rev_q   <= 1'b0;
			end else if (cmd.op == OP_BLEND) begin
				if (cmd.lane == 2'd0) thr_f_q <= nf[15:0];
				else str_f_q <= nf[15:0];
			end else if (cmd.op == OP_DECIDE) begin
				rev_q <= rev_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.go) begin
			unique case (cmd.op)
				OP_LOAD: begin
					val_q[0] <= thr_in;
					val_q[1] <= str_in;
					val_q[2] <= 18'(brk_in);
					speed_q  <= in_item.road_speed;
					hb_q     <= in_item.handbrake_raw;
					clr_q    <= in_item.command;
				end
				OP_DZ_START: if (mag < dz) val_q[cmd.lane] <= '0;
				OP_DZ_FINISH: if (cur != 0)
					val_q[cmd.lane] <= neg ? -18'(quot) : 18'(quot);
				OP_GAIN: val_q[cmd.lane] <= neg ? -18'(gres) : 18'(gres);
				OP_DECIDE: begin
					if (rev_n) begin
						result.drive_throttle <= brk[15:1];
						result.drive_brake    <= '0;
						result.drive_steering <= -str_f_q;
					end else begin
						result.drive_throttle <= tf[17] ? 15'd0 : tf[14:0];
						result.drive_brake    <= tf[17] ? 15'(-tf) : brk[14:0];
						result.drive_steering <= str_f_q;
					end
					result.drive_handbrake <= hb_q;
					result.reversing       <= rev_n;
				end
				default: ;
			endcase
		end
	end

	assign status.div_busy = div_busy;
	assign status.is_clear = clr_q;
endmodule

// File: sv/psic_ctrl.sv
// psic_ctrl: sequencer for one tick through the datapath steps
// depends on psic_pkg
module psic_ctrl import psic_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);
	typedef enum logic [2:0] {S_IDLE, S_CHECK, S_DZ, S_WAIT, S_FIN, S_GAIN, S_BLEND, S_DEC}
		state_t;
	state_t     state_q;
	logic [1:0] lane_q;
	logic       res_free;

	// result register can take a new beat this cycle
	assign res_free = !out_valid || out_ready;
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd.go = 1'b1;
		cmd.lane = lane_q;
		unique case (state_q)
			S_IDLE:  begin cmd.op = OP_LOAD; cmd.go = in_valid && in_ready; end
			S_CHECK: begin cmd.op = OP_CLEAR; cmd.go = status.is_clear; end
			S_DZ:    cmd.op = OP_DZ_START;
			S_WAIT:  begin cmd.op = OP_DZ_FINISH; cmd.go = 1'b0; end
			S_FIN:   cmd.op = OP_DZ_FINISH;
			S_GAIN:  cmd.op = OP_GAIN;
			S_BLEND: cmd.op = OP_BLEND;
			S_DEC:   begin cmd.op = OP_DECIDE; cmd.go = res_free; end
			default: begin cmd.op = OP_LOAD; cmd.go = 1'b0; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			lane_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			if (state_q == S_DEC && res_free) out_valid <= 1'b1;
			else if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_valid && in_ready) state_q <= S_CHECK;
				S_CHECK: begin
					lane_q  <= 2'd0;
					state_q <= status.is_clear ? S_IDLE : S_DZ;
				end
				S_DZ: state_q <= S_WAIT;
				S_WAIT: if (!status.div_busy) state_q <= S_FIN;
				S_FIN: state_q <= (lane_q == 2'd2) ? S_DEC : S_GAIN;
				S_GAIN: state_q <= S_BLEND;
				S_BLEND: begin
					lane_q  <= lane_q + 2'd1;
					state_q <= S_DZ;
				end
				S_DEC: if (res_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: sv/pedal_steering_input_conditioner.sv
// pedal_steering_input_conditioner: top level, config registers, controller and datapath
// depends on psic_pkg, psic_ctrl, psic_datapath
// three dead zone divisions per beat, one per axis, on one shared divider, plus check,
// gain, blend and decide steps; an axis inside its dead zone starts no division
// one tick at a time, no new beat until the last is done; a held result stalls only decide
// arst_n clears the smoothed state, reverse flag and handshake; config registers take reset values
module pedal_steering_input_conditioner import psic_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [14:0] cfg_data
);
	logic [10:0] thr_gain_q, str_gain_q;
	logic [13:0] dz_q;
	logic [14:0] blend_q;
	logic        auto_q;
	dp_cmd_t     cmd;
	dp_status_t  status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_gain_q <= 11'd256;
			str_gain_q <= 11'd256;
			dz_q       <= 14'd1638;
			blend_q    <= 15'd1787;
			auto_q     <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_THR_GAIN: thr_gain_q <= cfg_data[10:0];
				REG_STR_GAIN: str_gain_q <= cfg_data[10:0];
				REG_DZ:       dz_q       <= cfg_data[13:0];
				REG_BLEND:    blend_q    <= cfg_data;
				REG_AUTO_REV: auto_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	psic_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .status(status), .cmd(cmd)
	);

	psic_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .in_item(in_data),
		.thr_gain(thr_gain_q), .str_gain(str_gain_q), .dz_width(dz_q),
		.blend_rate(blend_q), .auto_rev(auto_q), .status(status), .result(out_data)
	);

`ifndef SYNTHESIS
	a_reverse_zero_brake: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.reversing |-> out_data.drive_brake == 15'd0)
		else $error("brake nonzero in reverse");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("beat taken while busy");
	a_throttle_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.drive_throttle <= 15'd16384)
		else $error("throttle out of range");
`endif
endmodule
